// File: design/modular_square_root_top_macros.svh
// ----------------------------------------------------------------------------
// modular_square_root_top_macros.svh
// Assertion macros used by the modular square root checker.
// ----------------------------------------------------------------------------
`ifndef MODULAR_SQUARE_ROOT_TOP_MACROS_SVH
`define MODULAR_SQUARE_ROOT_TOP_MACROS_SVH

// check a property on the rising clock, off while reset is low
`define MSQR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that a condition implies another in the same cycle, off while reset is low
`define MSQR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/msqr_pkg.sv
// ----------------------------------------------------------------------------
// msqr_pkg
// Types and constants shared by the modular square root controller and datapath.
// ----------------------------------------------------------------------------
package msqr_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned ZW     = 17;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_JINIT, OP_JINIT_Z, OP_JMOD, OP_JHALVE, OP_JSWAP, OP_SETA,
    OP_MUL, OP_COPY, OP_PINIT, OP_PSHIFT, OP_QINIT, OP_QSHIFT, OP_ZINIT, OP_ZINC,
    OP_EINIT, OP_EINC, OP_KINIT, OP_KINC, OP_SETS, OP_OUT_REG, OP_OUT_ZERO,
    OP_OUT_NONE, OP_OUT_BIT
  } op_e;

  typedef enum logic [3:0] {
    REG_A, REG_Z, REG_R, REG_T, REG_C, REG_B, REG_T2, REG_PR, REG_PB
  } reg_e;

  typedef enum logic [1:0] {EXP_P4, EXP_QH, EXP_Q} exp_e;

  typedef enum logic {JRET_A, JRET_Z} jret_e;

  typedef enum logic [1:0] {PRET_P3, PRET_R, PRET_T, PRET_C} pret_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CHK, ST_AMOD, ST_AMODW, ST_AZ, ST_JMOD, ST_JMODW, ST_JTEST,
    ST_PTEST, ST_PMULW, ST_PSQW, ST_QLOOP, ST_ZNEXT, ST_R2, ST_T2, ST_LSTART,
    ST_LTEST, ST_LSQW, ST_LEXIT, ST_KI, ST_KTEST, ST_KSQW, ST_LC, ST_WC, ST_WT,
    ST_WR
  } ctl_state_e;

  typedef struct packed {
    op_e  op;
    reg_e src_x;
    reg_e src_y;
    reg_e dst;
    exp_e exp;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic p_lt2;
    logic p_eq2;
    logic p_even;
    logic p_mod4_3;
    logic a_zero;
    logic ja_zero;
    logic ja_even;
    logic jn_one;
    logic jneg;
    logic pe_zero;
    logic pe_lsb;
    logic q_even;
    logic zlim;
    logic t2_one;
    logic e_zero;
    logic e_ge_s;
    logic k_done;
  } sts_t;

endpackage

// File: design/msqr_dp.sv
// ----------------------------------------------------------------------------
// msqr_dp
// Datapath: operand registers, serial modular multiplier, serial remainder
// unit for the Jacobi symbol, and the exponent and loop counters.
// ----------------------------------------------------------------------------
module msqr_dp #(
  parameter int unsigned WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WIDTH-1:0]   value_i,
  input  logic [WIDTH-1:0]   modulus_i,
  input  msqr_pkg::cmd_t     cmd_i,
  output msqr_pkg::sts_t     sts_o,
  output logic [WIDTH-1:0]   root_o,
  output logic               status_o,
  output logic               done_o
);
  import msqr_pkg::*;

  localparam int unsigned JW = (WIDTH > ZW) ? WIDTH : ZW;
  localparam int unsigned CW = $clog2(WIDTH + 1);
  localparam int unsigned DW = $clog2(JW + 1);
  localparam int unsigned SW = $clog2(WIDTH) + 1;

  logic [WIDTH-1:0] p_q, a_q, r_q, t_q, c_q, b_q, t2_q, pr_q, pb_q, pe_q, q_q;
  logic [ZW-1:0]    z_q;
  logic [JW-1:0]    ja_q, jn_q, rem_q;
  logic             jneg_q;
  logic [SW-1:0]    s_q, e_q, k_q;
  logic [WIDTH-1:0] mx_q, my_q, acc_q;
  logic [CW-1:0]    mcnt_q;
  reg_e             mdst_q;
  logic             mbusy_q;
  logic [DW-1:0]    dcnt_q;
  logic             dbusy_q;
  logic [WIDTH-1:0] root_q;
  logic             status_q, done_q;

  logic [JW-1:0]    z_ext;
  logic [WIDTH-1:0] xv, yv, wdata, mstep, d1;
  logic [WIDTH:0]   dbl, msum;
  logic [JW:0]      r2;
  logic [JW-1:0]    rstep;
  logic             wen;
  reg_e             wsel;
  logic [SW:0]      ke_sum;

  assign z_ext = JW'(z_q);

  function automatic logic [WIDTH-1:0] rd(input reg_e s);
    case (s)
      REG_A:   return a_q;
      REG_Z:   return z_ext[WIDTH-1:0];
      REG_R:   return r_q;
      REG_T:   return t_q;
      REG_C:   return c_q;
      REG_B:   return b_q;
      REG_T2:  return t2_q;
      REG_PR:  return pr_q;
      REG_PB:  return pb_q;
      default: return '0;
    endcase
  endfunction

  assign xv = rd(cmd_i.src_x);
  assign yv = rd(cmd_i.src_y);

  // double-and-add step of the modular multiplier
  always_comb begin
    dbl   = {acc_q, 1'b0};
    d1    = (dbl >= {1'b0, p_q}) ? WIDTH'(dbl - {1'b0, p_q}) : dbl[WIDTH-1:0];
    msum  = {1'b0, d1} + (my_q[WIDTH-1] ? {1'b0, mx_q} : '0);
    mstep = (msum >= {1'b0, p_q}) ? WIDTH'(msum - {1'b0, p_q}) : msum[WIDTH-1:0];
  end

  // shift-subtract step of the remainder unit
  always_comb begin
    r2    = {rem_q, ja_q[JW-1]};
    rstep = (r2 >= {1'b0, jn_q}) ? JW'(r2 - {1'b0, jn_q}) : r2[JW-1:0];
  end

  always_comb begin
    wen   = 1'b0;
    wsel  = cmd_i.dst;
    wdata = xv;
    case (cmd_i.op)
      OP_COPY, OP_EINIT, OP_PINIT: wen = 1'b1;
      OP_SETA: begin
        wen   = 1'b1;
        wsel  = REG_A;
        wdata = ja_q[WIDTH-1:0];
      end
      OP_LOAD: begin
        wen   = 1'b1;
        wsel  = REG_A;
        wdata = value_i;
      end
      default: ;
    endcase
    if (mbusy_q && mcnt_q == CW'(1)) begin
      wen   = 1'b1;
      wsel  = mdst_q;
      wdata = mstep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      case (wsel)
        REG_A:   a_q  <= wdata;
        REG_R:   r_q  <= wdata;
        REG_T:   t_q  <= wdata;
        REG_C:   c_q  <= wdata;
        REG_B:   b_q  <= wdata;
        REG_T2:  t2_q <= wdata;
        REG_PR:  pr_q <= wdata;
        REG_PB:  pb_q <= wdata;
        default: ;
      endcase
    end
    if (cmd_i.op == OP_PINIT) pr_q <= WIDTH'(1);
    case (cmd_i.op)
      OP_LOAD:   p_q <= modulus_i;
      OP_PINIT: begin
        case (cmd_i.exp)
          EXP_P4:  pe_q <= (p_q >> 2) + WIDTH'(1);
          EXP_QH:  pe_q <= (q_q >> 1) + WIDTH'(1);
          default: pe_q <= q_q;
        endcase
      end
      OP_PSHIFT: pe_q <= pe_q >> 1;
      OP_QINIT: begin
        q_q <= p_q - WIDTH'(1);
        s_q <= '0;
      end
      OP_QSHIFT: begin
        q_q <= q_q >> 1;
        s_q <= s_q + SW'(1);
      end
      OP_ZINIT:  z_q <= ZW'(2);
      OP_ZINC:   z_q <= z_q + ZW'(1);
      OP_EINIT:  e_q <= '0;
      OP_EINC:   e_q <= e_q + SW'(1);
      OP_KINIT:  k_q <= '0;
      OP_KINC:   k_q <= k_q + SW'(1);
      OP_SETS:   s_q <= e_q;
      OP_OUT_REG: begin
        root_q   <= xv;
        status_q <= 1'b0;
      end
      OP_OUT_ZERO: begin
        root_q   <= '0;
        status_q <= 1'b0;
      end
      OP_OUT_NONE: begin
        root_q   <= '0;
        status_q <= 1'b1;
      end
      OP_OUT_BIT: begin
        root_q   <= WIDTH'(a_q[0]);
        status_q <= 1'b0;
      end
      default: ;
    endcase
  end

  // jacobi operands and remainder unit
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_JINIT: begin
        ja_q   <= JW'(xv);
        jn_q   <= JW'(p_q);
        jneg_q <= 1'b0;
      end
      OP_JINIT_Z: begin
        ja_q   <= z_ext;
        jn_q   <= JW'(p_q);
        jneg_q <= 1'b0;
      end
      OP_JMOD: rem_q <= '0;
      OP_JHALVE: begin
        ja_q <= ja_q >> 1;
        if (jn_q[2:0] == 3'd3 || jn_q[2:0] == 3'd5) jneg_q <= ~jneg_q;
      end
      OP_JSWAP: begin
        ja_q <= jn_q;
        jn_q <= ja_q;
        if (ja_q[1:0] == 2'd3 && jn_q[1:0] == 2'd3) jneg_q <= ~jneg_q;
      end
      default: ;
    endcase
    if (dbusy_q) begin
      rem_q <= rstep;
      ja_q  <= (dcnt_q == DW'(1)) ? rstep : {ja_q[JW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MUL) begin
      mx_q   <= xv;
      my_q   <= yv;
      acc_q  <= '0;
      mdst_q <= cmd_i.dst;
    end else if (mbusy_q) begin
      acc_q <= mstep;
      my_q  <= my_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mcnt_q  <= '0;
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.op == OP_MUL) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= CW'(WIDTH);
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q - CW'(1);
        if (mcnt_q == CW'(1)) mbusy_q <= 1'b0;
      end
      if (cmd_i.op == OP_JMOD) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= DW'(JW);
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - DW'(1);
        if (dcnt_q == DW'(1)) dbusy_q <= 1'b0;
      end
      done_q <= (cmd_i.op == OP_OUT_REG) || (cmd_i.op == OP_OUT_ZERO) ||
                (cmd_i.op == OP_OUT_NONE) || (cmd_i.op == OP_OUT_BIT);
    end
  end

  assign ke_sum = {1'b0, k_q} + {1'b0, e_q} + (SW+1)'(1);

  always_comb begin
    sts_o.busy     = mbusy_q | dbusy_q;
    sts_o.p_lt2    = p_q < WIDTH'(2);
    sts_o.p_eq2    = p_q == WIDTH'(2);
    sts_o.p_even   = ~p_q[0];
    sts_o.p_mod4_3 = p_q[1:0] == 2'd3;
    sts_o.a_zero   = a_q == '0;
    sts_o.ja_zero  = ja_q == '0;
    sts_o.ja_even  = ~ja_q[0];
    sts_o.jn_one   = jn_q == JW'(1);
    sts_o.jneg     = jneg_q;
    sts_o.pe_zero  = pe_q == '0;
    sts_o.pe_lsb   = pe_q[0];
    sts_o.q_even   = ~q_q[0];
    sts_o.zlim     = z_q[ZW-1];
    sts_o.t2_one   = t2_q == WIDTH'(1);
    sts_o.e_zero   = e_q == '0;
    sts_o.e_ge_s   = e_q >= s_q;
    sts_o.k_done   = ke_sum >= {1'b0, s_q};
  end

  assign root_o   = root_q;
  assign status_o = status_q;
  assign done_o   = done_q;

endmodule

// File: design/msqr_ctrl.sv
// ----------------------------------------------------------------------------
// msqr_ctrl
// Controller: sequences the special cases, Jacobi symbols, exponentiations
// and the square-reduce loop as commands to the datapath.
// ----------------------------------------------------------------------------
module msqr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  msqr_pkg::sts_t  sts_i,
  output msqr_pkg::cmd_t  cmd_o
);
  import msqr_pkg::*;

  ctl_state_e state_q, state_d;
  jret_e      jret_q, jret_d;
  pret_e      pret_q, pret_d;

  function automatic cmd_t mk(input op_e op, input reg_e x, input reg_e y, input reg_e d,
                              input exp_e ex);
    cmd_t c;
    c.op    = op;
    c.src_x = x;
    c.src_y = y;
    c.dst   = d;
    c.exp   = ex;
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      jret_q  <= JRET_A;
      pret_q  <= PRET_P3;
    end else begin
      state_q <= state_d;
      jret_q  <= jret_d;
      pret_q  <= pret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    jret_d  = jret_q;
    pret_d  = pret_q;
    cmd_o   = mk(OP_NOP, REG_A, REG_A, REG_A, EXP_Q);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o   = mk(OP_LOAD, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        state_d = ST_IDLE;
        if (sts_i.p_lt2) cmd_o = mk(OP_OUT_ZERO, REG_A, REG_A, REG_A, EXP_Q);
        else if (sts_i.p_eq2) cmd_o = mk(OP_OUT_BIT, REG_A, REG_A, REG_A, EXP_Q);
        else if (sts_i.p_even) cmd_o = mk(OP_OUT_NONE, REG_A, REG_A, REG_A, EXP_Q);
        else begin
          cmd_o   = mk(OP_JINIT, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_AMOD;
        end
      end
      ST_AMOD: begin
        cmd_o   = mk(OP_JMOD, REG_A, REG_A, REG_A, EXP_Q);
        state_d = ST_AMODW;
      end
      ST_AMODW: begin
        if (!sts_i.busy) begin
          cmd_o   = mk(OP_SETA, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_AZ;
        end
      end
      ST_AZ: begin
        if (sts_i.a_zero) begin
          cmd_o   = mk(OP_OUT_ZERO, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_IDLE;
        end else begin
          cmd_o   = mk(OP_JINIT, REG_A, REG_A, REG_A, EXP_Q);
          jret_d  = JRET_A;
          state_d = ST_JMOD;
        end
      end
      ST_JMOD: begin
        cmd_o   = mk(OP_JMOD, REG_A, REG_A, REG_A, EXP_Q);
        state_d = ST_JMODW;
      end
      ST_JMODW: begin
        if (!sts_i.busy) state_d = ST_JTEST;
      end
      ST_JTEST: begin
        if (sts_i.ja_zero) begin
          if (jret_q == JRET_A) begin
            if (!(sts_i.jn_one && !sts_i.jneg)) begin
              cmd_o   = mk(OP_OUT_NONE, REG_A, REG_A, REG_A, EXP_Q);
              state_d = ST_IDLE;
            end else if (sts_i.p_mod4_3) begin
              cmd_o   = mk(OP_PINIT, REG_A, REG_A, REG_PB, EXP_P4);
              pret_d  = PRET_P3;
              state_d = ST_PTEST;
            end else begin
              cmd_o   = mk(OP_QINIT, REG_A, REG_A, REG_A, EXP_Q);
              state_d = ST_QLOOP;
            end
          end else begin
            if (sts_i.jn_one && sts_i.jneg) begin
              cmd_o   = mk(OP_PINIT, REG_A, REG_A, REG_PB, EXP_QH);
              pret_d  = PRET_R;
              state_d = ST_PTEST;
            end else if (sts_i.zlim) begin
              cmd_o   = mk(OP_OUT_NONE, REG_A, REG_A, REG_A, EXP_Q);
              state_d = ST_IDLE;
            end else begin
              cmd_o   = mk(OP_ZINC, REG_A, REG_A, REG_A, EXP_Q);
              state_d = ST_ZNEXT;
            end
          end
        end else if (sts_i.ja_even) begin
          cmd_o = mk(OP_JHALVE, REG_A, REG_A, REG_A, EXP_Q);
        end else begin
          cmd_o   = mk(OP_JSWAP, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_JMOD;
        end
      end
      ST_QLOOP: begin
        if (sts_i.q_even) cmd_o = mk(OP_QSHIFT, REG_A, REG_A, REG_A, EXP_Q);
        else begin
          cmd_o   = mk(OP_ZINIT, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_ZNEXT;
        end
      end
      ST_ZNEXT: begin
        cmd_o   = mk(OP_JINIT_Z, REG_A, REG_A, REG_A, EXP_Q);
        jret_d  = JRET_Z;
        state_d = ST_JMOD;
      end
      ST_PTEST: begin
        if (sts_i.pe_zero) begin
          case (pret_q)
            PRET_P3: begin
              cmd_o   = mk(OP_OUT_REG, REG_PR, REG_A, REG_A, EXP_Q);
              state_d = ST_IDLE;
            end
            PRET_R: begin
              cmd_o   = mk(OP_COPY, REG_PR, REG_A, REG_R, EXP_Q);
              state_d = ST_R2;
            end
            PRET_T: begin
              cmd_o   = mk(OP_COPY, REG_PR, REG_A, REG_T, EXP_Q);
              state_d = ST_T2;
            end
            default: begin
              cmd_o   = mk(OP_COPY, REG_PR, REG_A, REG_C, EXP_Q);
              state_d = ST_LSTART;
            end
          endcase
        end else if (sts_i.pe_lsb) begin
          cmd_o   = mk(OP_MUL, REG_PR, REG_PB, REG_PR, EXP_Q);
          state_d = ST_PMULW;
        end else begin
          cmd_o   = mk(OP_MUL, REG_PB, REG_PB, REG_PB, EXP_Q);
          state_d = ST_PSQW;
        end
      end
      ST_PMULW: begin
        if (!sts_i.busy) begin
          cmd_o   = mk(OP_MUL, REG_PB, REG_PB, REG_PB, EXP_Q);
          state_d = ST_PSQW;
        end
      end
      ST_PSQW: begin
        if (!sts_i.busy) begin
          cmd_o   = mk(OP_PSHIFT, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_PTEST;
        end
      end
      ST_R2: begin
        cmd_o   = mk(OP_PINIT, REG_A, REG_A, REG_PB, EXP_Q);
        pret_d  = PRET_T;
        state_d = ST_PTEST;
      end
      ST_T2: begin
        cmd_o   = mk(OP_PINIT, REG_Z, REG_A, REG_PB, EXP_Q);
        pret_d  = PRET_C;
        state_d = ST_PTEST;
      end
      ST_LSTART: begin
        cmd_o   = mk(OP_EINIT, REG_T, REG_A, REG_T2, EXP_Q);
        state_d = ST_LTEST;
      end
      ST_LTEST: begin
        if (sts_i.e_ge_s || sts_i.t2_one) state_d = ST_LEXIT;
        else begin
          cmd_o   = mk(OP_MUL, REG_T2, REG_T2, REG_T2, EXP_Q);
          state_d = ST_LSQW;
        end
      end
      ST_LSQW: begin
        if (!sts_i.busy) begin
          cmd_o   = mk(OP_EINC, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_LTEST;
        end
      end
      ST_LEXIT: begin
        if (sts_i.e_zero) begin
          cmd_o   = mk(OP_OUT_REG, REG_R, REG_A, REG_A, EXP_Q);
          state_d = ST_IDLE;
        end else if (sts_i.e_ge_s) begin
          cmd_o   = mk(OP_OUT_NONE, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_IDLE;
        end else begin
          cmd_o   = mk(OP_COPY, REG_C, REG_A, REG_B, EXP_Q);
          state_d = ST_KI;
        end
      end
      ST_KI: begin
        cmd_o   = mk(OP_KINIT, REG_A, REG_A, REG_A, EXP_Q);
        state_d = ST_KTEST;
      end
      ST_KTEST: begin
        if (sts_i.k_done) begin
          cmd_o   = mk(OP_SETS, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_LC;
        end else begin
          cmd_o   = mk(OP_MUL, REG_B, REG_B, REG_B, EXP_Q);
          state_d = ST_KSQW;
        end
      end
      ST_KSQW: begin
        if (!sts_i.busy) begin
          cmd_o   = mk(OP_KINC, REG_A, REG_A, REG_A, EXP_Q);
          state_d = ST_KTEST;
        end
      end
      ST_LC: begin
        cmd_o   = mk(OP_MUL, REG_B, REG_B, REG_C, EXP_Q);
        state_d = ST_WC;
      end
      ST_WC: begin
        if (!sts_i.busy) begin
          cmd_o   = mk(OP_MUL, REG_T, REG_C, REG_T, EXP_Q);
          state_d = ST_WT;
        end
      end
      ST_WT: begin
        if (!sts_i.busy) begin
          cmd_o   = mk(OP_MUL, REG_R, REG_B, REG_R, EXP_Q);
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        if (!sts_i.busy) state_d = ST_LSTART;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = state_q != ST_IDLE;

endmodule

// File: design/modular_square_root_top.sv
// ----------------------------------------------------------------------------
// modular_square_root_top
// Tonelli-Shanks square root modulo an odd prime, with Jacobi residue test.
// ----------------------------------------------------------------------------
// Usage: drive value_i and modulus_i and raise start while busy is low; the
// word is taken at that clock edge and busy rises on the next cycle. Only the
// low WIDTH bits of both inputs are used.
// When the work ends, done_o is high for exactly one cycle with root_o and status_o
// valid and busy falls in that same cycle; the receiver cannot hold the
// result, so it must take it then. status_o high means no root (root_o is 0).
// Latency depends on the data: every modular multiply runs on one shared
// double-and-add unit, every remainder step of the Jacobi symbol on one
// shift-subtract unit. A modulus that is 3 mod 4 costs about 2*WIDTH
// multiplies; the general case adds the non-residue search and up to s*s/2
// squarings, where p-1 = q*2^s. One word is worked at a time, so throughput
// equals latency.
// Reset clears the controller to idle; no result is pending after reset.
// ----------------------------------------------------------------------------
module modular_square_root_top #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [msqr_pkg::DATA_W-1:0]   value_i,
  input  logic [msqr_pkg::DATA_W-1:0]   modulus_i,
  output logic [msqr_pkg::DATA_W-1:0]   root_o,
  output logic                          status_o,
  output logic                          done_o
);
  import msqr_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [WIDTH-1:0] root;

  msqr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  msqr_dp #(.WIDTH(WIDTH)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .value_i   (value_i[WIDTH-1:0]),
    .modulus_i (modulus_i[WIDTH-1:0]),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .root_o    (root),
    .status_o  (status_o),
    .done_o    (done_o)
  );

  assign root_o = DATA_W'(root);

endmodule

// File: design/msqr_checker.sv
// ----------------------------------------------------------------------------
// msqr_checker
// Port-level checks on the modular square root block, bound to the top level.
// ----------------------------------------------------------------------------
`include "modular_square_root_top_macros.svh"

module msqr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [msqr_pkg::DATA_W-1:0] root_o,
  input logic                        status_o,
  input logic                        done_o
);
  `MSQR_ASSERT(a_start_busy, start && !busy |=> busy, "accepted word did not raise busy")
  `MSQR_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `MSQR_ASSERT_IMP(a_done_idle, done_o, !busy && $past(busy), "result outside end of work")
  `MSQR_ASSERT_IMP(a_none_zero, done_o && status_o, root_o == '0, "no-root result not zero")
endmodule

bind modular_square_root_top msqr_checker u_msqr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .root_o   (root_o),
  .status_o (status_o),
  .done_o   (done_o)
);
